/* sv/fuzzy_pid_gain_tuner_macros.svh */
// ----------------------------------------------------------------------------
// Fuzzy PID gain tuner assertion macros
// Clocked implication checks with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef FUZZY_PID_GAIN_TUNER_MACROS_SVH
`define FUZZY_PID_GAIN_TUNER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FPGT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fuzzy_pid_gain_tuner: same-cycle check failed");

`define FPGT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fuzzy_pid_gain_tuner: next-cycle check failed");

`else

`define FPGT_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define FPGT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/fpgt_pkg.sv */
// ----------------------------------------------------------------------------
// Fuzzy PID gain tuner package
// Shared widths, rule tables and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
package fpgt_pkg;

	localparam int SPAN_W = 16;
	localparam int Q_W = 15;
	localparam int W_W = 13;
	localparam int IDX_W = 3;
	localparam int OUT_W = 15;
	localparam int ACC_W = 28;
	localparam int OUT_TDATA_W = 48;
	localparam int PAIR_W = 2;

	localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd64;
	localparam logic signed [Q_W-1:0] Q_ONE = 15'sd4096;
	localparam logic signed [Q_W-1:0] Q_TWO = 15'sd8192;
	localparam logic signed [Q_W-1:0] Q_MAX = 15'sd12288;
	localparam logic [W_W-1:0] W_ONE = 13'd4096;
	localparam logic signed [ACC_W-1:0] ACC_HALF = 28'sd8388608;
	localparam int ACC_SHIFT = 24;

	localparam logic [1:0] MUL_ERR = 2'd0;
	localparam logic [1:0] MUL_DERR = 2'd1;
	localparam logic [1:0] MUL_WGT = 2'd2;

	typedef logic signed [2:0] rule_t;

	localparam rule_t RULE_P [0:6][0:6] = '{
		'{ 3,  3,  2,  2,  1,  0,  0},
		'{ 3,  3,  2,  1,  1,  0, -1},
		'{ 2,  2,  2,  1,  0, -1, -1},
		'{ 2,  2,  1,  0, -1, -2, -2},
		'{ 1,  1,  0, -1, -1, -2, -2},
		'{ 1,  0, -1, -2, -2, -2, -3},
		'{ 0,  0, -2, -2, -2, -3, -3}
	};

	localparam rule_t RULE_I [0:6][0:6] = '{
		'{-3, -3, -2, -2, -1,  0,  0},
		'{-3, -3, -2, -1, -1,  0,  0},
		'{-3, -2, -1, -1,  0,  1,  1},
		'{-2, -2, -1,  0,  1,  2,  2},
		'{-2, -1,  0,  1,  1,  2,  3},
		'{ 0,  0,  1,  1,  2,  3,  3},
		'{ 0,  0,  1,  2,  2,  3,  3}
	};

	localparam rule_t RULE_D [0:6][0:6] = '{
		'{ 1, -1, -3, -3, -3, -2,  1},
		'{ 1, -1, -3, -2, -2, -1,  0},
		'{ 0, -1, -2, -2, -1, -1,  0},
		'{ 0, -1, -1, -1, -1, -1,  0},
		'{ 0,  0,  0,  0,  0,  0,  0},
		'{ 3, -1,  1,  1,  1,  1,  3},
		'{ 3,  2,  2,  2,  1,  1,  3}
	};

	typedef struct packed {
		logic load_in;
		logic cfg_we;
		logic mul_en;
		logic [1:0] mul_sel;
		logic quant_e;
		logic quant_d;
		logic memb_en;
		logic acc_en;
		logic [PAIR_W-1:0] pair;
		logic load_out;
	} dp_cmd_t;

endpackage

/* sv/fpgt_datapath.sv */
// ----------------------------------------------------------------------------
// Fuzzy PID gain tuner datapath
// Error registers, shared multiplier, quantizer, memberships and rule sums.
// ----------------------------------------------------------------------------
module fpgt_datapath #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  fpgt_pkg::dp_cmd_t cmd,
	input  logic signed [SAMPLE_BITS-1:0] target_value,
	input  logic signed [SAMPLE_BITS-1:0] measured_value,
	input  logic [fpgt_pkg::SPAN_W-1:0] cfg_data,
	output logic signed [fpgt_pkg::OUT_W-1:0] delta_kp,
	output logic signed [fpgt_pkg::OUT_W-1:0] delta_ki,
	output logic signed [fpgt_pkg::OUT_W-1:0] delta_kd
);

	localparam int ERR_W = SAMPLE_BITS + 1;
	localparam int DERR_W = SAMPLE_BITS + 2;
	localparam int MA_W = (DERR_W > 14) ? DERR_W : 14;
	localparam int MB_W = fpgt_pkg::SPAN_W + 1;
	localparam int P_W = MA_W + MB_W;
	localparam int X_W = P_W + 3;
	localparam int Q_W = fpgt_pkg::Q_W;
	localparam int W_W = fpgt_pkg::W_W;
	localparam int IDX_W = fpgt_pkg::IDX_W;
	localparam int ACC_W = fpgt_pkg::ACC_W;

	typedef struct packed {
		logic [IDX_W-1:0] k;
		logic [W_W-1:0] w0;
		logic [W_W-1:0] w1;
	} memb_t;

	function automatic memb_t membership(input logic signed [Q_W-1:0] q);
		memb_t m;
		logic signed [Q_W-1:0] t;
		if (q < -fpgt_pkg::Q_TWO) begin
			m.k = 3'd0;
			t = q + fpgt_pkg::Q_MAX;
		end else if (q < -fpgt_pkg::Q_ONE) begin
			m.k = 3'd1;
			t = q + fpgt_pkg::Q_TWO;
		end else if (q < 15'sd0) begin
			m.k = 3'd2;
			t = q + fpgt_pkg::Q_ONE;
		end else if (q < fpgt_pkg::Q_ONE) begin
			m.k = 3'd3;
			t = q;
		end else if (q < fpgt_pkg::Q_TWO) begin
			m.k = 3'd4;
			t = q - fpgt_pkg::Q_ONE;
		end else begin
			m.k = 3'd5;
			t = q - fpgt_pkg::Q_TWO;
		end
		m.w1 = t[W_W-1:0];
		m.w0 = fpgt_pkg::W_ONE - t[W_W-1:0];
		return m;
	endfunction

	function automatic logic signed [ACC_W-1:0] rule_term(input logic [24:0] w,
		input fpgt_pkg::rule_t r);
		logic [2:0] mag;
		logic signed [ACC_W-1:0] wx;
		logic signed [ACC_W-1:0] t;
		mag = r[2] ? 3'(-r) : 3'(r);
		wx = signed'(ACC_W'(w));
		t = (mag[1] ? (wx <<< 1) : '0) + (mag[0] ? wx : '0);
		return r[2] ? -t : t;
	endfunction

	logic [fpgt_pkg::SPAN_W-1:0] span_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [DERR_W-1:0] derr_q;
	logic signed [P_W-1:0] prod_q;
	logic signed [Q_W-1:0] qe_q;
	logic signed [Q_W-1:0] qd_q;
	logic [IDX_W-1:0] ke_q;
	logic [IDX_W-1:0] kc_q;
	logic [W_W-1:0] we_q [2];
	logic [W_W-1:0] wc_q [2];
	logic signed [ACC_W-1:0] acc_p_q;
	logic signed [ACC_W-1:0] acc_i_q;
	logic signed [ACC_W-1:0] acc_d_q;
	logic signed [fpgt_pkg::OUT_W-1:0] kp_q;
	logic signed [fpgt_pkg::OUT_W-1:0] ki_q;
	logic signed [fpgt_pkg::OUT_W-1:0] kd_q;

	logic signed [ERR_W-1:0] err_c;
	logic signed [DERR_W-1:0] derr_c;
	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic signed [P_W-1:0] ma_x;
	logic signed [P_W-1:0] mb_x;
	logic signed [X_W-1:0] px;
	logic signed [X_W-1:0] scaled;
	logic signed [X_W-1:0] shifted;
	logic signed [Q_W-1:0] q_sat;
	memb_t me;
	memb_t mc;
	logic [IDX_W-1:0] idx_e;
	logic [IDX_W-1:0] idx_c;
	logic [24:0] w_prod;

	assign err_c = ERR_W'(target_value) - ERR_W'(measured_value);
	assign derr_c = DERR_W'(err_c) - DERR_W'(prev_err_q);

	always_comb begin
		case (cmd.mul_sel)
			fpgt_pkg::MUL_ERR: begin
				ma = MA_W'(err_q);
				mb = signed'(MB_W'(span_q));
			end
			fpgt_pkg::MUL_DERR: begin
				ma = MA_W'(derr_q);
				mb = signed'(MB_W'(span_q));
			end
			fpgt_pkg::MUL_WGT: begin
				ma = signed'(MA_W'(we_q[cmd.pair[1]]));
				mb = signed'(MB_W'(wc_q[cmd.pair[0]]));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		ma_x = P_W'(ma);
		mb_x = P_W'(mb);
	end

	always_comb begin
		px = X_W'(prod_q);
		scaled = cmd.quant_e ? (px <<< 2) + (px <<< 1) : (px <<< 1) + px;
		shifted = scaled >>> 4;
		if (shifted > X_W'(fpgt_pkg::Q_MAX)) begin
			q_sat = fpgt_pkg::Q_MAX;
		end else if (shifted < -X_W'(fpgt_pkg::Q_MAX)) begin
			q_sat = -fpgt_pkg::Q_MAX;
		end else begin
			q_sat = Q_W'(shifted);
		end
	end

	assign me = membership(qe_q);
	assign mc = membership(qd_q);
	assign idx_e = ke_q + IDX_W'(cmd.pair[1]);
	assign idx_c = kc_q + IDX_W'(cmd.pair[0]);
	assign w_prod = prod_q[24:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= fpgt_pkg::SPAN_RESET;
			prev_err_q <= '0;
		end else begin
			if (cmd.cfg_we) begin
				span_q <= cfg_data;
			end
			if (cmd.load_in) begin
				prev_err_q <= err_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			err_q <= err_c;
			derr_q <= derr_c;
		end
		if (cmd.mul_en) begin
			prod_q <= ma_x * mb_x;
		end
		if (cmd.quant_e) begin
			qe_q <= q_sat;
		end
		if (cmd.quant_d) begin
			qd_q <= q_sat;
		end
		if (cmd.memb_en) begin
			ke_q <= me.k;
			we_q[0] <= me.w0;
			we_q[1] <= me.w1;
			kc_q <= mc.k;
			wc_q[0] <= mc.w0;
			wc_q[1] <= mc.w1;
			acc_p_q <= fpgt_pkg::ACC_HALF;
			acc_i_q <= fpgt_pkg::ACC_HALF;
			acc_d_q <= fpgt_pkg::ACC_HALF;
		end
		if (cmd.acc_en) begin
			acc_p_q <= acc_p_q + rule_term(w_prod, fpgt_pkg::RULE_P[idx_e][idx_c]);
			acc_i_q <= acc_i_q + rule_term(w_prod, fpgt_pkg::RULE_I[idx_e][idx_c]);
			acc_d_q <= acc_d_q + rule_term(w_prod, fpgt_pkg::RULE_D[idx_e][idx_c]);
		end
		if (cmd.load_out) begin
			kp_q <= fpgt_pkg::OUT_W'(acc_p_q >>> fpgt_pkg::ACC_SHIFT);
			ki_q <= fpgt_pkg::OUT_W'(acc_i_q >>> fpgt_pkg::ACC_SHIFT);
			kd_q <= fpgt_pkg::OUT_W'(acc_d_q >>> fpgt_pkg::ACC_SHIFT);
		end
	end

	assign delta_kp = kp_q;
	assign delta_ki = ki_q;
	assign delta_kd = kd_q;

endmodule

/* sv/fpgt_ctrl.sv */
// ----------------------------------------------------------------------------
// Fuzzy PID gain tuner controller
// Sequences the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
`include "fuzzy_pid_gain_tuner_macros.svh"

module fpgt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic cfg_valid,
	output logic cfg_ready,
	output fpgt_pkg::dp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL_E = 4'd1;
	localparam logic [3:0] S_QNT_E = 4'd2;
	localparam logic [3:0] S_MUL_D = 4'd3;
	localparam logic [3:0] S_QNT_D = 4'd4;
	localparam logic [3:0] S_MEMB = 4'd5;
	localparam logic [3:0] S_MUL_W = 4'd6;
	localparam logic [3:0] S_ACC_W = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [fpgt_pkg::PAIR_W-1:0] pair_q;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.cfg_we = cfg_valid;
		cmd.pair = pair_q;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_MUL_E;
				end
			end
			S_MUL_E: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = fpgt_pkg::MUL_ERR;
				state_d = S_QNT_E;
			end
			S_QNT_E: begin
				cmd.quant_e = 1'b1;
				state_d = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = fpgt_pkg::MUL_DERR;
				state_d = S_QNT_D;
			end
			S_QNT_D: begin
				cmd.quant_d = 1'b1;
				state_d = S_MEMB;
			end
			S_MEMB: begin
				cmd.memb_en = 1'b1;
				state_d = S_MUL_W;
			end
			S_MUL_W: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = fpgt_pkg::MUL_WGT;
				state_d = S_ACC_W;
			end
			S_ACC_W: begin
				cmd.acc_en = 1'b1;
				state_d = (pair_q == '1) ? S_OUT : S_MUL_W;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pair_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.memb_en) begin
				pair_q <= '0;
			end else if (cmd.acc_en) begin
				pair_q <= pair_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`FPGT_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == S_MUL_E)
	`FPGT_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready)
	`FPGT_ASSERT_NEXT(a_last_pair, clk, arst_n, state_q == S_ACC_W && pair_q == '1, state_q == S_OUT)
	`FPGT_ASSERT_IMPL(a_one_step, clk, arst_n, 1'b1, $onehot0({cmd.load_in, cmd.mul_en, cmd.quant_e, cmd.quant_d, cmd.memb_en, cmd.acc_en, cmd.load_out}))

endmodule

/* sv/fuzzy_pid_gain_tuner.sv */
// ----------------------------------------------------------------------------
// Fuzzy PID gain tuner
// Fuzzy self-tuning of PID gain adjustments from a 7x7 rule base per gain.
// ----------------------------------------------------------------------------
// Each sample transfer carries a setpoint and a measurement; the block forms the
// error and its change against the previous error, quantizes both over [-3, 3]
// with the configured span reciprocal, and returns one transfer with the rounded
// delta Kp, Ki and Kd. A single shared multiplier serves the two quantizer
// products and the four membership weight products in turn. The next sample is
// accepted as soon as the previous one has reached the output register. The
// span reciprocal may be written at any time the block is idle.
module fuzzy_pid_gain_tuner #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fpgt_pkg::SPAN_W-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: target_value, measured_value, zero padding.
	input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0: delta_kp, delta_ki, delta_kd, zero padding.
	output logic [fpgt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int OUT_W = fpgt_pkg::OUT_W;

	fpgt_pkg::dp_cmd_t cmd;
	logic signed [SAMPLE_BITS-1:0] target_value;
	logic signed [SAMPLE_BITS-1:0] measured_value;
	logic signed [OUT_W-1:0] delta_kp;
	logic signed [OUT_W-1:0] delta_ki;
	logic signed [OUT_W-1:0] delta_kd;

	assign target_value = s_axis_tdata[SAMPLE_BITS-1:0];
	assign measured_value = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign m_axis_tdata = {{(fpgt_pkg::OUT_TDATA_W - 3 * OUT_W){1'b0}},
		delta_kd, delta_ki, delta_kp};

	fpgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	fpgt_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.target_value   (target_value),
		.measured_value (measured_value),
		.cfg_data       (cfg_data),
		.delta_kp       (delta_kp),
		.delta_ki       (delta_ki),
		.delta_kd       (delta_kd)
	);

endmodule

/* test/fuzzy_pid_gain_tuner_tb.sv */
// ----------------------------------------------------------------------------
// Fuzzy PID gain tuner testbench
// Drives setpoint and measurement samples through the stream input, throttles
// the result stream, and compares every delta Kp, Ki and Kd transfer against
// an in-bench fuzzy inference predictor across several span settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef enum int {GAIN_P = 0, GAIN_I = 1, GAIN_D = 2} gain_e;
typedef logic signed [fpgt_pkg::OUT_W-1:0] gain_delta_t;

typedef struct packed {
	gain_delta_t kd;
	gain_delta_t ki;
	gain_delta_t kp;
} gain_set_t;

class gain_scoreboard;
	int rule [3][7][7];
	gain_set_t gain_q [$];
	logic [15:0] span;
	longint prev_error;
	int failures;

	function new();
		rule[GAIN_P] = '{
			'{ 3,  3,  2,  2,  1,  0,  0},
			'{ 3,  3,  2,  1,  1,  0, -1},
			'{ 2,  2,  2,  1,  0, -1, -1},
			'{ 2,  2,  1,  0, -1, -2, -2},
			'{ 1,  1,  0, -1, -1, -2, -2},
			'{ 1,  0, -1, -2, -2, -2, -3},
			'{ 0,  0, -2, -2, -2, -3, -3}
		};
		rule[GAIN_I] = '{
			'{-3, -3, -2, -2, -1,  0,  0},
			'{-3, -3, -2, -1, -1,  0,  0},
			'{-3, -2, -1, -1,  0,  1,  1},
			'{-2, -2, -1,  0,  1,  2,  2},
			'{-2, -1,  0,  1,  1,  2,  3},
			'{ 0,  0,  1,  1,  2,  3,  3},
			'{ 0,  0,  1,  2,  2,  3,  3}
		};
		rule[GAIN_D] = '{
			'{ 1, -1, -3, -3, -3, -2,  1},
			'{ 1, -1, -3, -2, -2, -1,  0},
			'{ 0, -1, -2, -2, -1, -1,  0},
			'{ 0, -1, -1, -1, -1, -1,  0},
			'{ 0,  0,  0,  0,  0,  0,  0},
			'{ 3, -1,  1,  1,  1,  1,  3},
			'{ 3,  2,  2,  2,  1,  1,  3}
		};
		span = fpgt_pkg::SPAN_RESET;
		prev_error = 0;
		failures = 0;
	endfunction

	function void set_span(logic [15:0] value);
		span = value;
	endfunction

	function longint quantize(longint x, longint scale);
		longint q;
		q = (scale * x * longint'(span)) >>> 4;
		if (q > 12288)
			q = 12288;
		if (q < -12288)
			q = -12288;
		return q;
	endfunction

	// The upper set of the segment gets the offset from the lower centre.
	function void fuzzify(input longint q, output int seg, output longint upper_w);
		if (q < -8192)
			seg = 0;
		else if (q < -4096)
			seg = 1;
		else if (q < 0)
			seg = 2;
		else if (q < 4096)
			seg = 3;
		else if (q < 8192)
			seg = 4;
		else
			seg = 5;
		upper_w = q - longint'(seg - 3) * 4096;
	endfunction

	function void note_sample(logic signed [15:0] tgt, logic signed [15:0] mea);
		longint err;
		longint derr;
		longint we;
		longint wc;
		longint sum;
		int se;
		int sc;
		gain_delta_t delta [3];
		gain_set_t want;
		err = longint'(tgt) - longint'(mea);
		derr = err - prev_error;
		fuzzify(quantize(err, 6), se, we);
		fuzzify(quantize(derr, 3), sc, wc);
		for (int g = 0; g < 3; g++) begin
			sum = (4096 - we) * (4096 - wc) * rule[g][se][sc]
				+ (4096 - we) * wc * rule[g][se][sc + 1]
				+ we * (4096 - wc) * rule[g][se + 1][sc]
				+ we * wc * rule[g][se + 1][sc + 1];
			sum = (sum + 2048 * 4096) >>> 24;
			delta[g] = sum[14:0];
		end
		want.kp = delta[GAIN_P];
		want.ki = delta[GAIN_I];
		want.kd = delta[GAIN_D];
		gain_q.push_back(want);
		prev_error = err;
	endfunction

	function void check_result(logic [fpgt_pkg::OUT_TDATA_W-1:0] tdata);
		gain_set_t got;
		gain_set_t want;
		got = tdata[44:0];
		if (gain_q.size() == 0) begin
			$error("Result transfer arrived with no sample waiting: %h", tdata);
			failures++;
			return;
		end
		want = gain_q.pop_front();
		if (got.kp !== want.kp) begin
			$error("delta_kp mismatch: expected %0d, actual %0d", want.kp, got.kp);
			failures++;
		end
		if (got.ki !== want.ki) begin
			$error("delta_ki mismatch: expected %0d, actual %0d", want.ki, got.ki);
			failures++;
		end
		if (got.kd !== want.kd) begin
			$error("delta_kd mismatch: expected %0d, actual %0d", want.kd, got.kd);
			failures++;
		end
	endfunction

	function int outstanding();
		return gain_q.size();
	endfunction
endclass

module fuzzy_pid_gain_tuner_tb;

	localparam int LATENCY = 14;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 190;
	localparam int PHASES = 10;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_LONG} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fpgt_pkg::SPAN_W-1:0] cfg_data = fpgt_pkg::SPAN_RESET;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// Fields from bit 0: target_value, measured_value.
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// Fields from bit 0: delta_kp, delta_ki, delta_kd, zero padding.
	logic [fpgt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	gain_scoreboard sb;
	int burst_left = 0;
	longint last_err = 0;
	int stall_cycles = 0;
	rx_mode_e rx_mode = RX_OPEN;
	int rx_mode_left = 0;
	int rx_hold = 0;

	fuzzy_pid_gain_tuner #(
		.SAMPLE_BITS(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(2));
			rx_mode_left <= $urandom_range(400, 50);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			case (rx_mode)
				RX_OPEN: m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= 1'($urandom_range(1));
				default: begin
					m_axis_tready <= ~m_axis_tready;
					rx_hold <= $urandom_range(15);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic longint spread(longint reach);
		return longint'($urandom_range(32'(2 * reach))) - reach;
	endfunction

	task automatic send_sample(input logic signed [15:0] tgt, input logic signed [15:0] mea);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {mea, tgt};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_sample(tgt, mea);
		last_err = longint'(tgt) - longint'(mea);
	endtask

	task automatic send_error(input longint err);
		longint lo;
		longint hi;
		longint mea;
		if (err > 65535)
			err = 65535;
		if (err < -65535)
			err = -65535;
		lo = (err > 0) ? -32768 : -32768 - err;
		hi = (err > 0) ? 32767 - err : 32767;
		mea = lo + longint'($urandom_range(32'(hi - lo)));
		send_sample(16'(mea + err), 16'(mea));
	endtask

	task automatic hold_off();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic write_span(input logic [15:0] value);
		hold_off();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		sb.set_span(value);
	endtask

	// Most samples keep the error near the unsaturated band of the current span.
	task automatic random_phase(input logic [15:0] span, input bit with_pause);
		longint reach;
		int pick;
		write_span(span);
		reach = (span == 0) ? 65535 : 32768 / span + 1;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (with_pause && i == PHASE_ITEMS / 2)
				hold_off();
			pick = $urandom_range(99);
			if (pick < 15)
				send_sample(16'($urandom), 16'($urandom));
			else if (pick < 35)
				send_error(last_err + spread(reach / 4 + 1));
			else
				send_error(spread(reach + reach / 4));
		end
	endtask

	initial begin
		logic [15:0] phase_span [PHASES];
		int b;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_span(16'd64);
		send_sample(0, 0);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(-32768, 32767);
		send_sample(512, 0);
		send_sample(0, 512);
		send_sample(100, 0);
		send_sample(100, 0);
		send_sample(-100, 0);
		send_sample(1, 0);
		send_sample(0, 1);
		send_sample(32767, 32767);
		send_sample(-32768, -32768);
		send_sample(21845, -21846);

		write_span(16'd1);
		send_sample(1, 0);
		send_sample(0, 1);
		send_sample(-1, 0);
		send_sample(-1, 0);

		write_span(16'hFFFF);
		send_sample(0, 1);
		send_sample(1, 0);
		send_sample(-1, -1);

		write_span(16'd0);
		send_sample(1234, -5678);
		send_sample(32767, -32768);

		phase_span = '{16'd64, 16'd1, 16'hFFFF, 16'd3, 16'd37, 16'd200, 16'd1000,
			16'd4096, 16'd0, 16'd0};
		for (int p = PHASES - 2; p < PHASES; p++) begin
			b = $urandom_range(15);
			phase_span[p] = 16'((1 << b) | ($urandom & ((1 << b) - 1)));
		end
		for (int p = 0; p < PHASES; p++)
			random_phase(phase_span[p], p == 1 || p == 6);

		hold_off();
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/fpgt_pkg.sv
sv/fpgt_datapath.sv
sv/fpgt_ctrl.sv
sv/fuzzy_pid_gain_tuner.sv
test/fuzzy_pid_gain_tuner_tb.sv
